>>> rtl/core/spring_damper_smoother_assert.svh
// ----------------------------------------------------------------------------
// spring damper smoother assertion macros
// concurrent checks clocked on clk_i, off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef SPRING_DAMPER_SMOOTHER_ASSERT_SVH
`define SPRING_DAMPER_SMOOTHER_ASSERT_SVH

// same-cycle implication
`define SDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sds_pkg.sv
// ----------------------------------------------------------------------------
// sds_pkg
// types, constants, saturation and the microcode rom of the smoother
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sds_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PC_W       = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPRING_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX   = 3'd4;

  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [47:0] WIDE_MAX = 48'sh0000_7fff_ffff;
  localparam logic signed [47:0] WIDE_MIN = 48'shffff_8000_0000;

  // register reset values, 1.0 gain and a two pi range
  localparam logic signed [31:0] RST_SPRING_GAIN = 32'sd65536;
  localparam logic signed [31:0] RST_RANGE_MAX   = 32'sd411775;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_LIN_PREP,
    UOP_MUL_G,
    UOP_MUL_D,
    UOP_VSUM,
    UOP_MUL_T,
    UOP_LIN_RES,
    UOP_W_SPAN,
    UOP_W_OPND,
    UOP_W_ADD,
    UOP_W_FIX,
    UOP_W_LIM
  } uop_e;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_DT_ZERO,
    COND_WRAP
  } cond_e;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  typedef struct packed {
    uop_e  uop;
    cond_e cond;
    pc_t   target;
    logic  done;
  } ucode_t;

  typedef struct packed {
    logic load_in;
    logic load_out;
    uop_e uop;
  } ctrl_t;

  typedef struct packed {
    logic dt_zero;
    logic wrap;
  } flags_t;

  typedef struct packed {
    logic              wrap_mode;
    logic signed [31:0] spring_gain;
    logic signed [31:0] damping;
    logic signed [31:0] range_min;
    logic signed [31:0] range_max;
  } cfg_t;

  // program addresses
  localparam pc_t PC_ENTRY    = 4'd0;
  localparam pc_t PC_LIN_PREP = 4'd1;
  localparam pc_t PC_MUL_G    = 4'd2;
  localparam pc_t PC_MUL_D    = 4'd3;
  localparam pc_t PC_VSUM     = 4'd4;
  localparam pc_t PC_MUL_T    = 4'd5;
  localparam pc_t PC_LIN_RES  = 4'd6;
  localparam pc_t PC_W_SPAN   = 4'd7;
  localparam pc_t PC_W_OPND   = 4'd8;
  localparam pc_t PC_W_ADD    = 4'd9;
  localparam pc_t PC_W_FIX    = 4'd10;
  localparam pc_t PC_W_LIM    = 4'd11;
  localparam pc_t PC_FIN      = 4'd12;

  // saturate a wide signed value to q16.16
  function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > WIDE_MAX) begin
      r = Q_MAX;
    end else if (v < WIDE_MIN) begin
      r = Q_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // microcode rom
  function automatic ucode_t sds_rom(input pc_t pc);
    ucode_t w;
    case (pc)
      PC_ENTRY:    w = '{uop: UOP_NOP,      cond: COND_DT_ZERO, target: PC_FIN,    done: 1'b0};
      PC_LIN_PREP: w = '{uop: UOP_LIN_PREP, cond: COND_WRAP,    target: PC_W_SPAN, done: 1'b0};
      PC_MUL_G:    w = '{uop: UOP_MUL_G,    cond: COND_NEXT,    target: PC_ENTRY,  done: 1'b0};
      PC_MUL_D:    w = '{uop: UOP_MUL_D,    cond: COND_NEXT,    target: PC_ENTRY,  done: 1'b0};
      PC_VSUM:     w = '{uop: UOP_VSUM,     cond: COND_NEXT,    target: PC_ENTRY,  done: 1'b0};
      PC_MUL_T:    w = '{uop: UOP_MUL_T,    cond: COND_WRAP,    target: PC_W_ADD,  done: 1'b0};
      PC_LIN_RES:  w = '{uop: UOP_LIN_RES,  cond: COND_ALWAYS,  target: PC_FIN,    done: 1'b0};
      PC_W_SPAN:   w = '{uop: UOP_W_SPAN,   cond: COND_NEXT,    target: PC_ENTRY,  done: 1'b0};
      PC_W_OPND:   w = '{uop: UOP_W_OPND,   cond: COND_ALWAYS,  target: PC_MUL_G,  done: 1'b0};
      PC_W_ADD:    w = '{uop: UOP_W_ADD,    cond: COND_NEXT,    target: PC_ENTRY,  done: 1'b0};
      PC_W_FIX:    w = '{uop: UOP_W_FIX,    cond: COND_NEXT,    target: PC_ENTRY,  done: 1'b0};
      PC_W_LIM:    w = '{uop: UOP_W_LIM,    cond: COND_NEXT,    target: PC_ENTRY,  done: 1'b0};
      PC_FIN:      w = '{uop: UOP_NOP,      cond: COND_NEXT,    target: PC_ENTRY,  done: 1'b1};
      default:     w = '{uop: UOP_NOP,      cond: COND_ALWAYS,  target: PC_FIN,    done: 1'b0};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/sds_in_if.sv
// ----------------------------------------------------------------------------
// sds_in_if
// request channel: target and time step with valid and ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sds_in_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] target;
  logic [15:0]       time_step;

  modport source (output valid, output target, output time_step, input ready);
  modport sink   (input valid, input target, input time_step, output ready);
endinterface

>>> rtl/core/sds_out_if.sv
// ----------------------------------------------------------------------------
// sds_out_if
// result channel: new value and velocity with valid and ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sds_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] new_value;
  logic signed [31:0] new_velocity;

  modport source (output valid, output new_value, output new_velocity, input ready);
  modport sink   (input valid, input new_value, input new_velocity, output ready);
endinterface

>>> rtl/core/sds_seq.sv
// ----------------------------------------------------------------------------
// sds_seq
// step counter, microcode fetch, jumps and the request handshakes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "spring_damper_smoother_assert.svh"

module sds_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  input  sds_pkg::flags_t flags_i,
  output sds_pkg::ctrl_t  ctrl_o
);
  import sds_pkg::*;

  seq_state_e state_q, state_d;
  pc_t        pc_q, pc_d;
  logic       out_valid_q, out_valid_d;
  ucode_t     uw;
  logic       take;

  assign uw = sds_rom(pc_q);

  always_comb begin
    case (uw.cond)
      COND_NEXT:    take = 1'b0;
      COND_ALWAYS:  take = 1'b1;
      COND_DT_ZERO: take = flags_i.dt_zero;
      COND_WRAP:    take = flags_i.wrap;
      default:      take = 1'b0;
    endcase
  end

  always_comb begin
    state_d         = state_q;
    pc_d            = pc_q;
    in_ready_o      = 1'b0;
    ctrl_o.load_in  = 1'b0;
    ctrl_o.load_out = 1'b0;
    ctrl_o.uop      = UOP_NOP;
    case (state_q)
      SEQ_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load_in = 1'b1;
          state_d        = SEQ_RUN;
          pc_d           = PC_ENTRY;
        end
      end
      SEQ_RUN: begin
        ctrl_o.uop = uw.uop;
        if (uw.done) begin
          // hand over once the result register is free
          if (!out_valid_q || out_ready_i) begin
            ctrl_o.load_out = 1'b1;
            state_d         = SEQ_IDLE;
          end
        end else begin
          pc_d = take ? uw.target : pc_q + pc_t'(1);
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
    out_valid_d = ctrl_o.load_out | (out_valid_q & ~out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_IDLE;
      pc_q        <= PC_ENTRY;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `SDS_ASSERT_NEXT(a_start_at_entry, in_valid_i && in_ready_o,
                   state_q == SEQ_RUN && pc_q == PC_ENTRY,
                   "accepted request did not start the program at entry")
  `SDS_ASSERT_NEXT(a_run_to_end, state_q == SEQ_RUN && !uw.done,
                   state_q == SEQ_RUN,
                   "program left run before its final step")
  `SDS_ASSERT_NEXT(a_hold_when_full,
                   state_q == SEQ_RUN && uw.done && out_valid_q && !out_ready_i,
                   state_q == SEQ_RUN && $stable(pc_q),
                   "final step passed while the result register was full")

endmodule

>>> rtl/core/sds_dp.sv
// ----------------------------------------------------------------------------
// sds_dp
// datapath: state, operands, shared multiplier, adders and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "spring_damper_smoother_assert.svh"

module sds_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sds_pkg::ctrl_t     ctrl_i,
  input  sds_pkg::cfg_t      cfg_i,
  input  logic signed [31:0] target_i,
  input  logic [15:0]        time_step_i,
  output sds_pkg::flags_t    flags_o,
  output logic signed [31:0] new_value_o,
  output logic signed [31:0] new_velocity_o
);
  import sds_pkg::*;

  logic signed [31:0] target_q;
  logic [15:0]        dt_q;
  logic signed [31:0] cur_q, cur_d;
  logic signed [31:0] vel_q, vel_d;
  logic signed [31:0] a_q, a_d;
  logic signed [31:0] b_q, b_d;
  logic signed [31:0] acc_q, acc_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [32:0] span_q, span_d;
  logic [31:0]        dabs_q, dabs_d;
  logic               gt_q, gt_d;
  logic signed [31:0] vabs_q, vabs_d;
  logic signed [33:0] res_q, res_d;
  logic signed [31:0] out_value_q, out_vel_q;

  logic signed [31:0] mul_x, mul_y;
  logic signed [63:0] mul_p;
  logic signed [31:0] qprod, step32;
  logic signed [32:0] diff33, ndiff33;
  logic signed [34:0] twice35, span35;
  logic               far, up;
  logic signed [33:0] dabs34, dd34;
  logic signed [31:0] dsat, dneg;
  logic signed [47:0] vsum, rsum;
  logic signed [33:0] step34, spanx, nspan, stepc, maxx, minx;

  // shared multiplier operand select
  always_comb begin
    case (ctrl_i.uop)
      UOP_MUL_G: begin
        mul_x = a_q;
        mul_y = cfg_i.spring_gain;
      end
      UOP_MUL_D: begin
        mul_x = b_q;
        mul_y = cfg_i.damping;
      end
      default: begin
        mul_x = vel_q;
        mul_y = $signed({16'd0, dt_q});
      end
    endcase
  end

  assign mul_p  = mul_x * mul_y;
  // floor shift by 16 then saturate
  assign qprod  = sat48(prod_q[63:16]);
  assign step32 = prod_q[47:16];

  assign diff33  = $signed({target_q[31], target_q}) - $signed({cur_q[31], cur_q});
  assign ndiff33 = -diff33;

  // wrap operand shaping
  assign twice35 = $signed({2'b00, dabs_q, 1'b0});
  assign span35  = $signed({{2{span_q[32]}}, span_q});
  assign far     = twice35 > span35;
  assign up      = gt_q ? !far : far;
  assign dabs34  = $signed({2'b00, dabs_q});
  assign dd34    = far ? ($signed({span_q[32], span_q}) - dabs34) : dabs34;
  assign dsat    = sat48($signed({{14{dd34[33]}}, dd34}));
  assign dneg    = (dsat == Q_MIN) ? Q_MAX : -dsat;

  assign vsum = $signed({{16{acc_q[31]}}, acc_q}) + $signed({{16{qprod[31]}}, qprod});
  assign rsum = $signed({{16{cur_q[31]}}, cur_q}) + $signed({{16{step32[31]}}, step32});

  assign step34 = $signed({{2{step32[31]}}, step32});
  assign spanx  = $signed({span_q[32], span_q});
  assign nspan  = -spanx;
  assign stepc  = (step34 > spanx) ? spanx : ((step34 < nspan) ? nspan : step34);
  assign maxx   = $signed({{2{cfg_i.range_max[31]}}, cfg_i.range_max});
  assign minx   = $signed({{2{cfg_i.range_min[31]}}, cfg_i.range_min});

  always_comb begin
    cur_d  = cur_q;
    vel_d  = vel_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    prod_d = prod_q;
    span_d = span_q;
    dabs_d = dabs_q;
    gt_d   = gt_q;
    vabs_d = vabs_q;
    res_d  = res_q;
    case (ctrl_i.uop)
      UOP_NOP: ;
      UOP_LIN_PREP: begin
        a_d = sat48($signed({{15{diff33[32]}}, diff33}));
        b_d = vel_q;
      end
      UOP_MUL_G: prod_d = mul_p;
      UOP_MUL_D: begin
        acc_d  = qprod;
        prod_d = mul_p;
      end
      UOP_VSUM:    vel_d  = sat48(vsum);
      UOP_MUL_T:   prod_d = mul_p;
      UOP_LIN_RES: cur_d  = sat48(rsum);
      UOP_W_SPAN: begin
        span_d = $signed({cfg_i.range_max[31], cfg_i.range_max})
               - $signed({cfg_i.range_min[31], cfg_i.range_min});
        dabs_d = diff33[32] ? ndiff33[31:0] : diff33[31:0];
        gt_d   = !diff33[32] && (diff33 != 33'sd0);
        vabs_d = (vel_q == Q_MIN) ? Q_MAX : (vel_q[31] ? -vel_q : vel_q);
      end
      UOP_W_OPND: begin
        a_d = up ? dsat : dneg;
        b_d = up ? vabs_q : -vabs_q;
      end
      UOP_W_ADD: res_d = $signed({{2{cur_q[31]}}, cur_q}) + stepc;
      UOP_W_FIX: begin
        // one correction across the range
        if (res_q > maxx) begin
          res_d = res_q - spanx;
        end else if (res_q < minx) begin
          res_d = res_q + spanx;
        end
      end
      UOP_W_LIM: begin
        if (span_q <= 33'sd0) begin
          cur_d = cfg_i.range_min;
        end else if (res_q > maxx) begin
          cur_d = cfg_i.range_max;
        end else if (res_q < minx) begin
          cur_d = cfg_i.range_min;
        end else begin
          cur_d = res_q[31:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
      vel_q <= '0;
    end else begin
      cur_q <= cur_d;
      vel_q <= vel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    span_q <= span_d;
    dabs_q <= dabs_d;
    gt_q   <= gt_d;
    vabs_q <= vabs_d;
    res_q  <= res_d;
    if (ctrl_i.load_in) begin
      target_q <= target_i;
      dt_q     <= time_step_i;
    end
    if (ctrl_i.load_out) begin
      out_value_q <= cur_q;
      out_vel_q   <= vel_q;
    end
  end

  assign flags_o.dt_zero = (dt_q == 16'd0);
  assign flags_o.wrap    = cfg_i.wrap_mode;
  assign new_value_o     = out_value_q;
  assign new_velocity_o  = out_vel_q;

  `SDS_ASSERT_NEXT(a_wrap_in_range,
                   ctrl_i.uop == UOP_W_LIM && span_q > 33'sd0 &&
                   cfg_i.range_max > cfg_i.range_min,
                   cur_q >= $past(cfg_i.range_min) && cur_q <= $past(cfg_i.range_max),
                   "wrapped value left the range")
  `SDS_ASSERT_NEXT(a_nop_keeps_state, ctrl_i.uop == UOP_NOP,
                   $stable(cur_q) && $stable(vel_q),
                   "state changed on an idle step")

endmodule

>>> rtl/core/spring_damper_smoother.sv
// ----------------------------------------------------------------------------
// spring_damper_smoother
// spring damper smoothing of a q16.16 value with optional angle wrap
//
//   port     dir   request content                       handshake
//   in_i     in    target (s32 q16.16), time_step (u16)  valid / ready
//   out_o    out   new_value, new_velocity (s32 q16.16)  valid / ready
//   cfg_*    in    register index and 32 bit data        write enable only
//
// program: a request is taken, then the microcode runs on the single shared
//   32x32 multiplier; a zero time step jumps from entry to the final step,
//   wrap mode adds span, operand, add, fix and limit steps to linear mode;
//   requests wait for the end; one step per cycle unless the final step stalls
// reset: asynchronous active low; value and velocity clear to zero, registers
//   take their defaults (gain 1.0, range 0 to two pi)
// stalls: the result register frees the core, so the next request is taken
//   while a result waits; the final step holds only if a second result is due
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spring_damper_smoother (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  sds_in_if.sink                         in_i,
  sds_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [sds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sds_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sds_pkg::*;

  cfg_t   cfg_q, cfg_d;
  ctrl_t  ctrl;
  flags_t flags;

  // configuration registers: user must write only between requests, not enforced
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WRAP_MODE:   cfg_d.wrap_mode   = cfg_data_i[0];
        REG_SPRING_GAIN: cfg_d.spring_gain = $signed(cfg_data_i);
        REG_DAMPING:     cfg_d.damping     = $signed(cfg_data_i);
        REG_RANGE_MIN:   cfg_d.range_min   = $signed(cfg_data_i);
        REG_RANGE_MAX:   cfg_d.range_max   = $signed(cfg_data_i);
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wrap_mode   <= 1'b0;
      cfg_q.spring_gain <= RST_SPRING_GAIN;
      cfg_q.damping     <= '0;
      cfg_q.range_min   <= '0;
      cfg_q.range_max   <= RST_RANGE_MAX;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // step counter and microcode rom; one datapath word per cycle unless stalled
  sds_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .flags_i     (flags),
    .ctrl_o      (ctrl)
  );

  // value and velocity state, shared multiplier, wrap logic, result register
  sds_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .cfg_i          (cfg_q),
    .target_i       (in_i.target),
    .time_step_i    (in_i.time_step),
    .flags_o        (flags),
    .new_value_o    (out_o.new_value),
    .new_velocity_o (out_o.new_velocity)
  );

endmodule
